[rtl/alist_pkg.sv]
package alist_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = 7;
  localparam int WORD_W = 32;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(10);
  // a zero capacity falls back to the reset value, clipped to the store depth
  localparam logic [CNT_W-1:0] CAP_DFLT = (DEPTH < 10) ? CNT_W'(DEPTH) : CNT_W'(10);
  localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(DEPTH);

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_EDIT   = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_GET    = 3'd4;
  localparam logic [2:0] OP_FIND   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_BADINDEX = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_SHIFT,
    S_DEL_SHIFT,
    S_FIND_SCAN,
    S_GET_WAIT,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_CNT,
    CUR_POS,
    CUR_ZERO,
    CUR_INC,
    CUR_DEC
  } cur_op_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_CUR_M1,
    RD_CUR_P1,
    RD_CUR,
    RD_POS
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_TAIL,
    WR_POS,
    WR_PEND
  } wr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_OK,
    RES_OVF,
    RES_BAD,
    RES_GET,
    RES_HIT
  } res_sel_t;

  typedef struct packed {
    logic     load;
    cur_op_t  cur_op;
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    cnt_op_t  cnt_op;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       pos_le_cnt;
    logic       pos_lt_cnt;
    logic       cur_gt_pos;
    logic       cur_p1_lt_cnt;
    logic       cur_lt_cnt;
    logic       pend;
    logic       match;
  } stat_t;

endpackage

[rtl/alist_ctrl.sv]
module alist_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  alist_pkg::stat_t stat,
  output alist_pkg::cmd_t  cmd
);
  import alist_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat.op)
          OP_INSERT: begin
            if (stat.pos_le_cnt && !stat.full) state_nxt = S_INS_SHIFT;
            else state_nxt = S_FINISH;
          end
          OP_DELETE: begin
            if (stat.pos_lt_cnt) state_nxt = S_DEL_SHIFT;
            else state_nxt = S_FINISH;
          end
          OP_GET: begin
            if (stat.pos_lt_cnt) state_nxt = S_GET_WAIT;
            else state_nxt = S_FINISH;
          end
          OP_FIND: state_nxt = S_FIND_SCAN;
          default: state_nxt = S_FINISH;
        endcase
      end
      S_INS_SHIFT: begin
        if (!stat.cur_gt_pos && !stat.pend) state_nxt = S_FINISH;
      end
      S_DEL_SHIFT: begin
        if (!stat.cur_p1_lt_cnt && !stat.pend) state_nxt = S_FINISH;
      end
      S_FIND_SCAN: begin
        if (stat.pend && stat.match) state_nxt = S_FINISH;
        else if (!stat.cur_lt_cnt && !stat.pend) state_nxt = S_FINISH;
      end
      S_GET_WAIT: state_nxt = S_FINISH;
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.cur_op   = CUR_HOLD;
    cmd.rd_sel   = RD_NONE;
    cmd.wr_sel   = WR_NONE;
    cmd.cnt_op   = CNT_HOLD;
    cmd.res_sel  = RES_NONE;
    unique case (state_r)
      S_IDLE: cmd.load = in_valid;
      S_DECODE: begin
        cmd.res_sel = RES_OK;
        unique case (stat.op)
          OP_APPEND: begin
            if (stat.full) begin
              cmd.res_sel = RES_OVF;
            end else begin
              cmd.wr_sel = WR_TAIL;
              cmd.cnt_op = CNT_INC;
            end
          end
          OP_INSERT: begin
            if (!stat.pos_le_cnt) cmd.res_sel = RES_BAD;
            else if (stat.full) cmd.res_sel = RES_OVF;
            else cmd.cur_op = CUR_CNT;
          end
          OP_EDIT: begin
            if (!stat.pos_lt_cnt) cmd.res_sel = RES_BAD;
            else cmd.wr_sel = WR_POS;
          end
          OP_DELETE: begin
            if (!stat.pos_lt_cnt) cmd.res_sel = RES_BAD;
            else cmd.cur_op = CUR_POS;
          end
          OP_GET: begin
            if (!stat.pos_lt_cnt) cmd.res_sel = RES_BAD;
            else cmd.rd_sel = RD_POS;
          end
          OP_FIND: cmd.cur_op = CUR_ZERO;
          default: cmd.res_sel = RES_OK;
        endcase
      end
      S_INS_SHIFT: begin
        // move entry cur-1 up to cur, then drop the new word into the gap
        if (stat.pend) cmd.wr_sel = WR_PEND;
        if (stat.cur_gt_pos) begin
          cmd.rd_sel = RD_CUR_M1;
          cmd.cur_op = CUR_DEC;
        end else if (!stat.pend) begin
          cmd.wr_sel = WR_POS;
          cmd.cnt_op = CNT_INC;
        end
      end
      S_DEL_SHIFT: begin
        if (stat.pend) cmd.wr_sel = WR_PEND;
        if (stat.cur_p1_lt_cnt) begin
          cmd.rd_sel = RD_CUR_P1;
          cmd.cur_op = CUR_INC;
        end else if (!stat.pend) begin
          cmd.cnt_op = CNT_DEC;
        end
      end
      S_FIND_SCAN: begin
        if (stat.pend && stat.match) begin
          cmd.res_sel = RES_HIT;
        end else if (stat.cur_lt_cnt) begin
          cmd.rd_sel = RD_CUR;
          cmd.cur_op = CUR_INC;
        end
      end
      S_GET_WAIT: cmd.res_sel = RES_GET;
      S_FINISH: cmd.out_load = out_free;
      default: cmd.load = 1'b0;
    endcase
  end

endmodule

[rtl/alist_dp.sv]
module alist_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  alist_pkg::cmd_t             cmd,
  output alist_pkg::stat_t            stat,
  input  logic                        cfg_wr,
  input  logic [alist_pkg::CNT_W-1:0] cfg_capacity,
  input  logic [2:0]                  in_opcode,
  input  logic [6:0]                  in_position,
  input  logic signed [31:0]          in_word_in,
  output logic [1:0]                  out_status,
  output logic signed [31:0]          out_word_out,
  output logic                        out_hit,
  output logic [5:0]                  out_hit_position,
  output logic [alist_pkg::CNT_W-1:0] out_entries,
  output logic                        out_is_empty,
  output logic                        out_is_full
);
  import alist_pkg::*;

  logic [WORD_W-1:0] store_mem [DEPTH];

  logic [2:0]        op_r;
  logic [6:0]        pos_r;
  logic [WORD_W-1:0] word_r;
  logic [CNT_W-1:0]  cap_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  cur_r, cur_nxt;
  logic              pend_r;
  logic [IDX_W-1:0]  pend_addr_r;
  logic [WORD_W-1:0] rdata_r;

  logic [1:0]        st_status_r;
  logic [WORD_W-1:0] st_word_r;
  logic              st_hit_r;
  logic [IDX_W-1:0]  st_hpos_r;

  logic [CNT_W-1:0]  eff_cap;
  logic              full;
  logic [CNT_W-1:0]  cur_m1, cur_p1;
  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;

  always_comb begin
    if (cap_r == '0) eff_cap = CAP_DFLT;
    else if (cap_r > CAP_MAX) eff_cap = CAP_MAX;
    else eff_cap = cap_r;
  end

  assign full   = (count_r >= eff_cap);
  assign cur_m1 = cur_r - CNT_W'(1);
  assign cur_p1 = cur_r + CNT_W'(1);

  assign stat.op            = op_r;
  assign stat.full          = full;
  assign stat.pos_le_cnt    = (pos_r <= count_r);
  assign stat.pos_lt_cnt    = (pos_r < count_r);
  assign stat.cur_gt_pos    = (cur_r > pos_r);
  assign stat.cur_p1_lt_cnt = (cur_p1 < count_r);
  assign stat.cur_lt_cnt    = (cur_r < count_r);
  assign stat.pend          = pend_r;
  assign stat.match         = (rdata_r == word_r);

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    case (cmd.rd_sel)
      RD_CUR_M1: rd_addr = cur_m1[IDX_W-1:0];
      RD_CUR_P1: rd_addr = cur_p1[IDX_W-1:0];
      RD_CUR:    rd_addr = cur_r[IDX_W-1:0];
      RD_POS:    rd_addr = pos_r[IDX_W-1:0];
      default:   rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_data = word_r;
    case (cmd.wr_sel)
      WR_TAIL: wr_addr = count_r[IDX_W-1:0];
      WR_POS:  wr_addr = pos_r[IDX_W-1:0];
      WR_PEND: begin
        wr_addr = pend_addr_r;
        wr_data = rdata_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) store_mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= store_mem[rd_addr];
  end

  always_comb begin
    cur_nxt = cur_r;
    case (cmd.cur_op)
      CUR_CNT:  cur_nxt = count_r;
      CUR_POS:  cur_nxt = pos_r;
      CUR_ZERO: cur_nxt = '0;
      CUR_INC:  cur_nxt = cur_p1;
      CUR_DEC:  cur_nxt = cur_m1;
      default:  cur_nxt = cur_r;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    case (cmd.cnt_op)
      CNT_INC: count_nxt = count_r + CNT_W'(1);
      CNT_DEC: count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= CAP_RESET;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= rd_en;
      if (cfg_wr) cap_r <= cfg_capacity;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (rd_en) pend_addr_r <= cur_r[IDX_W-1:0];
    if (cmd.load) begin
      op_r   <= in_opcode;
      pos_r  <= in_position;
      word_r <= in_word_in;
    end
    case (cmd.res_sel)
      RES_OK: begin
        st_status_r <= ST_OK;
        st_word_r   <= '0;
        st_hit_r    <= 1'b0;
        st_hpos_r   <= '0;
      end
      RES_OVF: begin
        st_status_r <= ST_OVERFLOW;
        st_word_r   <= '0;
        st_hit_r    <= 1'b0;
        st_hpos_r   <= '0;
      end
      RES_BAD: begin
        st_status_r <= ST_BADINDEX;
        st_word_r   <= '0;
        st_hit_r    <= 1'b0;
        st_hpos_r   <= '0;
      end
      RES_GET: begin
        st_status_r <= ST_OK;
        st_word_r   <= rdata_r;
        st_hit_r    <= 1'b0;
        st_hpos_r   <= '0;
      end
      RES_HIT: begin
        st_status_r <= ST_OK;
        st_word_r   <= '0;
        st_hit_r    <= 1'b1;
        st_hpos_r   <= pend_addr_r;
      end
      default: st_hit_r <= st_hit_r;
    endcase
    if (cmd.out_load) begin
      out_status       <= st_status_r;
      out_word_out     <= st_word_r;
      out_hit          <= st_hit_r;
      out_hit_position <= 6'(st_hpos_r);
      out_entries      <= count_r;
      out_is_empty     <= (count_r == '0);
      out_is_full      <= full;
    end
  end

endmodule

[rtl/array_list_engine.sv]
// Packed list of signed 32-bit words, up to 64 entries, limited by a capacity
// register (cfg channel, reset value 10; zero selects 10, larger values clip
// to 64). cfg_ready is always high; write only while the block is idle.
// Input beats carry opcode, position and word; each accepted beat returns
// exactly one result beat with status, word_out, hit, hit_position, entries
// and the empty and full flags.
// One request is in flight at a time; in_ready is high only while idle, so
// with the receiver ready a new beat is taken in the cycle out_valid rises.
// Append, edit, rejected requests and unused opcodes go from decode straight
// to finish; get adds a read wait; insert and delete shift the entries and
// find scans them, stopping at the first match. The entry memory does one
// read and one write per cycle; insert, delete and find walk the entries one
// per cycle. Insert and delete overlap each read with the write of the entry
// before it; find only reads.
// A finished result sits in the output register until taken; a new beat is
// accepted meanwhile, and its result waits for the register to drain.
// Reset (synchronous, active low) empties the list, restores capacity 10 and
// drops any pending result. Entry contents are not cleared; only entries
// below the count are ever read.
module array_list_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [alist_pkg::CNT_W-1:0] cfg_capacity,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_opcode,
  input  logic [6:0]                  in_position,
  input  logic signed [31:0]          in_word_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic signed [31:0]          out_word_out,
  output logic                        out_hit,
  output logic [5:0]                  out_hit_position,
  output logic [alist_pkg::CNT_W-1:0] out_entries,
  output logic                        out_is_empty,
  output logic                        out_is_full
);
  import alist_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  alist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  alist_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_capacity     (cfg_capacity),
    .in_opcode        (in_opcode),
    .in_position      (in_position),
    .in_word_in       (in_word_in),
    .out_status       (out_status),
    .out_word_out     (out_word_out),
    .out_hit          (out_hit),
    .out_hit_position (out_hit_position),
    .out_entries      (out_entries),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a request is in flight");

  a_entries_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entries <= CNT_W'(DEPTH)))
    else $error("entry count beyond store depth");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entries == '0)))
    else $error("empty flag disagrees with entry count");

  a_error_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_word_out == '0 && !out_hit))
    else $error("failed request carries data");

endmodule
